FILE: hdl/ordered_list_insert_delete_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list unit
// Implication checks on the rising clock edge, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// same-cycle implication
`define OLID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OLID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/olid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_pkg
// Word types, action and status codes for the ordered list unit.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int POS_W     = 8;

  localparam logic [1:0] ACT_APPEND  = 2'd0;
  localparam logic [1:0] ACT_DEL_VAL = 2'd1;
  localparam logic [1:0] ACT_DEL_POS = 2'd2;
  localparam logic [1:0] ACT_SHOW    = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_SHOWN    = 3'd5;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [31:0] value;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] item_value;
    logic               last;
  } rsp_t;

endpackage

FILE: hdl/ordered_list_insert_delete_unit.sv
`timescale 1ns / 1ps
// Append: writes the entry on acceptance; the reply state loads the result word.
// Delete by value: compares entries from the head, then moves later ones up.
// Delete by position: moves each entry behind it one place toward the head.
// Read out: one result word per entry; one request at a time (stalled while busy).
// Sequencer steps one entry at a time through a store with one write port
// and a registered read port. Reset clears the count and sequencer, not the store.
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_unit
// Ordered list of signed 32-bit values with append, delete by value,
// delete by position and read out, stepped by a small sequencer.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_delete_unit_macros.svh"

module ordered_list_insert_delete_unit #(
  parameter int DEPTH = olid_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  olid_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output olid_pkg::rsp_t rsp
);

  import olid_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SRCH_RD  = 8'b0000_0010,
    S_SRCH_CHK = 8'b0000_0100,
    S_SHIFT_RD = 8'b0000_1000,
    S_SHIFT_WR = 8'b0001_0000,
    S_SHOW_RD  = 8'b0010_0000,
    S_SHOW_PUT = 8'b0100_0000,
    S_REPLY    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [2:0]    res_status, res_status_next;
  logic signed [31:0] key;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic signed [31:0] mem_wd;

  logic          req_acc;
  logic          out_free;
  logic          out_load;
  rsp_t          out_word;
  logic [CW-1:0] ptr_inc;
  logic [POS_W-1:0] cnt_ext;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign ptr_inc   = ptr + 1'b1;
  assign cnt_ext   = POS_W'(count);

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    res_status_next = res_status;
    rd_addr         = ptr[AW-1:0];
    mem_we          = 1'b0;
    mem_wa          = count[AW-1:0];
    mem_wd          = req.value;
    out_load        = 1'b0;
    out_word        = '0;
    out_word.last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (req_acc) begin
          ptr_next   = '0;
          state_next = S_REPLY;
          case (req.action)
            ACT_APPEND: begin
              if (count == FULL_CNT) begin
                res_status_next = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                count_next      = count + 1'b1;
                res_status_next = ST_DONE;
              end
            end
            ACT_DEL_VAL: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                state_next = S_SRCH_RD;
              end
            end
            ACT_DEL_POS: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else if (req.position == '0 || req.position > cnt_ext) begin
                res_status_next = ST_RANGE;
              end else begin
                ptr_next   = CW'(req.position - 1'b1);
                state_next = S_SHIFT_RD;
              end
            end
            default: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                state_next = S_SHOW_RD;
              end
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (rd_data == key) begin
          state_next = S_SHIFT_RD;
        end else if (ptr_inc == count) begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_REPLY;
        end else begin
          ptr_next   = ptr_inc;
          state_next = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        // close the gap: fetch the entry behind the hole
        if (ptr_inc < count) begin
          rd_addr    = ptr_inc[AW-1:0];
          state_next = S_SHIFT_WR;
        end else begin
          count_next      = count - 1'b1;
          res_status_next = ST_DONE;
          state_next      = S_REPLY;
        end
      end
      S_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_wa     = ptr[AW-1:0];
        mem_wd     = rd_data;
        ptr_next   = ptr_inc;
        state_next = S_SHIFT_RD;
      end
      S_SHOW_RD: begin
        state_next = S_SHOW_PUT;
      end
      S_SHOW_PUT: begin
        // hold until the output word is free
        if (out_free) begin
          out_load            = 1'b1;
          out_word.status     = ST_SHOWN;
          out_word.item_value = rd_data;
          out_word.last       = (ptr_inc == count);
          if (ptr_inc == count) begin
            state_next = S_IDLE;
          end else begin
            ptr_next   = ptr_inc;
            state_next = S_SHOW_RD;
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_word.status = res_status;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    res_status <= res_status_next;
    if (req_acc) begin
      key <= req.value;
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= out_word;
    end
  end

  `OLID_ASSERT_NOW(a_count_max, clk, rst, 1'b1, count <= FULL_CNT, "entry count beyond depth")
  `OLID_ASSERT_NEXT(a_append_grow, clk, rst, req_acc && req.action == ACT_APPEND && count != FULL_CNT, count == $past(count) + 1'b1, "append did not grow the list")
  `OLID_ASSERT_NOW(a_mid_is_shown, clk, rst, rsp_valid && !rsp.last, rsp.status == ST_SHOWN, "non-final word is not a shown element")
  `OLID_ASSERT_NOW(a_zero_value, clk, rst, rsp_valid && rsp.status != ST_SHOWN, rsp.item_value == '0, "status word carries a value")

endmodule
